/* rtl/assert_macros.svh */
// Assertion helpers for the RTL files; only grid_index_convert includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define GIC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Property that must hold at every clock edge outside reset.
`define GIC_ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

`endif

/* rtl/gic_pkg.sv */
// ----------------------------------------------------------------------------
// gic_pkg
// Types and constants of the grid index converter.
// ----------------------------------------------------------------------------
package gic_pkg;

    localparam int FIELD_DIMS = 4;
    localparam int SIZE_W     = 16;
    localparam int INDEX_W    = 31;
    localparam int PROD_W     = 32;
    localparam int CFG_IDX_W  = 3;

    localparam logic [PROD_W-1:0]  INDEX_LIMIT = 32'h8000_0000;
    localparam logic [INDEX_W-1:0] INDEX_MASK  = 31'h7FFF_FFFF;

    localparam logic OP_SPLIT   = 1'b0;
    localparam logic OP_COMPOSE = 1'b1;

    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_NO_DIMS = 2'd1,
        STATUS_RANGE   = 2'd2
    } t_status;

    localparam logic [CFG_IDX_W-1:0] REG_NUM_DIMS   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DIM_SIZE_0 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DIM_SIZE_1 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DIM_SIZE_2 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DIM_SIZE_3 = 3'd4;

    // One item on its way through the quotient stages.
    typedef struct packed {
        logic                                  op;
        logic                                  no_dims;
        logic                                  oor;
        logic [INDEX_W-1:0]                    rem;
        logic [FIELD_DIMS-1:0][PROD_W-1:0]     stride;
        logic [FIELD_DIMS-1:0][SIZE_W-1:0]     coord;
        logic [PROD_W-1:0]                     acc;
    } t_item;

endpackage

/* rtl/gic_prep.sv */
// ----------------------------------------------------------------------------
// gic_prep
// Front stages: strides, grid size, the Horner compose and the range compare.
// ----------------------------------------------------------------------------
module gic_prep
    import gic_pkg::*;
#(
    parameter int MAX_DIMS = 4
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_adv,
    input  logic                              i_valid,
    input  logic                              i_op,
    input  logic [INDEX_W-1:0]                i_index_in,
    input  logic [FIELD_DIMS-1:0][SIZE_W-1:0] i_coord_in,
    input  logic [2:0]                        i_num_dims,
    input  logic [FIELD_DIMS-1:0][SIZE_W-1:0] i_dim_size,
    output logic                              o_valid,
    output t_item                             o_item
);

    localparam int          CAP_I = (MAX_DIMS < FIELD_DIMS) ? MAX_DIMS : FIELD_DIMS;
    localparam logic [2:0]  CAP   = 3'(CAP_I);
    localparam int          NSTG  = 4;

    typedef struct packed {
        logic                              op;
        logic [FIELD_DIMS-1:0]             in_use;
        logic [FIELD_DIMS-1:0][SIZE_W-1:0] m;
        logic [FIELD_DIMS-1:0][SIZE_W-1:0] c;
        logic [INDEX_W-1:0]                idx;
        logic [FIELD_DIMS-1:0][PROD_W-1:0] stride;
        logic [PROD_W-1:0]                 acc;
        logic [PROD_W-1:0]                 total;
    } t_pre;

    function automatic logic [PROD_W-1:0] sat_mul(input logic [SIZE_W-1:0] a,
                                                  input logic [PROD_W-1:0] b);
        logic [SIZE_W+PROD_W-1:0] p;
        p = {{PROD_W{1'b0}}, a} * {{SIZE_W{1'b0}}, b};
        return (p > {{SIZE_W{1'b0}}, INDEX_LIMIT}) ? INDEX_LIMIT : p[PROD_W-1:0];
    endfunction

    function automatic logic [PROD_W-1:0] horner(input logic [SIZE_W-1:0] a,
                                                 input logic [PROD_W-1:0] acc,
                                                 input logic [SIZE_W-1:0] c);
        logic [SIZE_W+PROD_W-1:0] p;
        p = {{PROD_W{1'b0}}, a} * {{SIZE_W{1'b0}}, acc} + {{PROD_W{1'b0}}, c};
        return (p > {{SIZE_W{1'b0}}, INDEX_LIMIT}) ? INDEX_LIMIT : p[PROD_W-1:0];
    endfunction

    t_pre               r_p  [NSTG];
    logic [NSTG-1:0]    r_pv;
    t_pre               n_p  [NSTG];
    t_item              r_item;
    t_item              n_item;
    logic               r_valid;
    logic [2:0]         n_dims;

    always_comb begin
        n_dims = (i_num_dims > CAP) ? CAP : i_num_dims;

        n_p[0]        = '0;
        n_p[0].op     = i_op;
        n_p[0].c      = i_coord_in;
        n_p[0].idx    = i_index_in;
        for (int d = 0; d < FIELD_DIMS; d++) begin
            n_p[0].in_use[d] = (3'(d) < n_dims);
            n_p[0].m[d]      = n_p[0].in_use[d] ? i_dim_size[d] : SIZE_W'(1);
        end
        n_p[0].acc = {{(PROD_W-SIZE_W){1'b0}}, i_coord_in[0]};

        // Stage 1: the three fastest strides and the first Horner step.
        n_p[1]           = r_p[0];
        n_p[1].stride[3] = PROD_W'(1);
        n_p[1].stride[2] = {{(PROD_W-SIZE_W){1'b0}}, r_p[0].m[3]};
        n_p[1].stride[1] = {{(PROD_W-SIZE_W){1'b0}}, r_p[0].m[2]}
                         * {{(PROD_W-SIZE_W){1'b0}}, r_p[0].m[3]};
        if (r_p[0].in_use[1]) begin
            n_p[1].acc = horner(r_p[0].m[1], r_p[0].acc, r_p[0].c[1]);
        end

        n_p[2]           = r_p[1];
        n_p[2].stride[0] = sat_mul(r_p[1].m[1], r_p[1].stride[1]);
        if (r_p[1].in_use[2]) begin
            n_p[2].acc = horner(r_p[1].m[2], r_p[1].acc, r_p[1].c[2]);
        end

        n_p[3]       = r_p[2];
        n_p[3].total = sat_mul(r_p[2].m[0], r_p[2].stride[0]);
        if (r_p[2].in_use[3]) begin
            n_p[3].acc = horner(r_p[2].m[3], r_p[2].acc, r_p[2].c[3]);
        end

        n_item         = '0;
        n_item.op      = r_p[3].op;
        n_item.no_dims = !r_p[3].in_use[0];
        n_item.oor     = ({1'b0, r_p[3].idx} >= r_p[3].total);
        n_item.rem     = r_p[3].idx;
        n_item.stride  = r_p[3].stride;
        n_item.acc     = r_p[3].acc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv    <= '0;
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_pv    <= {r_pv[NSTG-2:0], i_valid};
            r_valid <= r_pv[NSTG-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            for (int k = 0; k < NSTG; k++) begin
                r_p[k] <= n_p[k];
            end
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

/* rtl/gic_divbit.sv */
// ----------------------------------------------------------------------------
// gic_divbit
// One restoring-division stage: settles one quotient bit of one coordinate.
// ----------------------------------------------------------------------------
module gic_divbit
    import gic_pkg::*;
#(
    parameter int DIM = 0,
    parameter int BIT = 0
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_adv,
    input  logic  i_valid,
    input  t_item i_item,
    output logic  o_valid,
    output t_item o_item
);

    localparam int WIDE_W = PROD_W + SIZE_W;

    logic [WIDE_W-1:0] shifted;
    logic [WIDE_W-1:0] rem_wide;
    t_item             n_item;
    t_item             r_item;
    logic              r_valid;

    always_comb begin
        shifted  = {{SIZE_W{1'b0}}, i_item.stride[DIM]} << BIT;
        rem_wide = {{(WIDE_W-INDEX_W){1'b0}}, i_item.rem};
        n_item   = i_item;
        if (rem_wide >= shifted) begin
            n_item.rem              = i_item.rem - shifted[INDEX_W-1:0];
            n_item.coord[DIM][BIT]  = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

/* rtl/grid_index_convert.sv */
// ----------------------------------------------------------------------------
// grid_index_convert
// Row-major linear index to grid coordinates and back, fully pipelined.
// ----------------------------------------------------------------------------
// Channel | Direction | Handshake               | Payload
// input   | in        | i_in_valid / o_in_stall | i_op, i_index_in, i_coord_in_0..3
// output  | out       | o_out_valid / i_out_stall | o_coord_out_0..3, o_index_out, o_status
// config  | in        | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// One item enters per cycle while the output is not stalled. Five front stages (input
// register, three multiply stages for strides, grid size and Horner, range
// compare), 64 one-bit quotient stages, one output register.
// Reset clears all valid bits and sets one dimension of size one.
// A stall on the output freezes the whole pipeline, so nothing is lost or repeated.
// ----------------------------------------------------------------------------
module grid_index_convert
    import gic_pkg::*;
#(
    parameter int MAX_DIMS = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic                 i_op,
    input  logic [INDEX_W-1:0]   i_index_in,
    input  logic [SIZE_W-1:0]    i_coord_in_0,
    input  logic [SIZE_W-1:0]    i_coord_in_1,
    input  logic [SIZE_W-1:0]    i_coord_in_2,
    input  logic [SIZE_W-1:0]    i_coord_in_3,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [SIZE_W-1:0]    o_coord_out_0,
    output logic [SIZE_W-1:0]    o_coord_out_1,
    output logic [SIZE_W-1:0]    o_coord_out_2,
    output logic [SIZE_W-1:0]    o_coord_out_3,
    output logic [INDEX_W-1:0]   o_index_out,
    output logic [1:0]           o_status,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [SIZE_W-1:0]    i_cfg_data
);

`include "assert_macros.svh"

    localparam int NDIV = FIELD_DIMS * SIZE_W;

    logic [2:0]                        r_num_dims;
    logic [FIELD_DIMS-1:0][SIZE_W-1:0] r_dim_size;
    logic                              adv;
    logic [FIELD_DIMS-1:0][SIZE_W-1:0] coord_in;
    logic [NDIV:0]                     s_valid;
    t_item                             s_item [NDIV+1];
    t_item                             last;
    logic                              r_out_valid;
    logic [FIELD_DIMS-1:0][SIZE_W-1:0] r_coord;
    logic [FIELD_DIMS-1:0][SIZE_W-1:0] n_coord;
    logic [INDEX_W-1:0]                r_index;
    logic [INDEX_W-1:0]                n_index;
    t_status                           r_status;
    t_status                           n_status;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_dims <= 3'd1;
            r_dim_size <= {FIELD_DIMS{SIZE_W'(1)}};
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_NUM_DIMS:   r_num_dims    <= i_cfg_data[2:0];
                REG_DIM_SIZE_0: r_dim_size[0] <= i_cfg_data;
                REG_DIM_SIZE_1: r_dim_size[1] <= i_cfg_data;
                REG_DIM_SIZE_2: r_dim_size[2] <= i_cfg_data;
                REG_DIM_SIZE_3: r_dim_size[3] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign adv        = !(r_out_valid && i_out_stall);
    assign o_in_stall = !adv;
    assign coord_in   = {i_coord_in_3, i_coord_in_2, i_coord_in_1, i_coord_in_0};

    gic_prep #(
        .MAX_DIMS (MAX_DIMS)
    ) u_prep (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_adv      (adv),
        .i_valid    (i_in_valid),
        .i_op       (i_op),
        .i_index_in (i_index_in),
        .i_coord_in (coord_in),
        .i_num_dims (r_num_dims),
        .i_dim_size (r_dim_size),
        .o_valid    (s_valid[0]),
        .o_item     (s_item[0])
    );

    // Dimension 0 first, most significant quotient bit first.
    for (genvar d = 0; d < FIELD_DIMS; d++) begin : g_dim
        for (genvar b = 0; b < SIZE_W; b++) begin : g_bit
            localparam int K = d * SIZE_W + (SIZE_W - 1 - b);
            gic_divbit #(
                .DIM (d),
                .BIT (b)
            ) u_divbit (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_adv   (adv),
                .i_valid (s_valid[K]),
                .i_item  (s_item[K]),
                .o_valid (s_valid[K+1]),
                .o_item  (s_item[K+1])
            );
        end
    end

    assign last = s_item[NDIV];

    always_comb begin
        n_coord  = '0;
        n_index  = '0;
        n_status = STATUS_OK;
        if (last.no_dims) begin
            n_status = STATUS_NO_DIMS;
        end else if (last.op == OP_SPLIT) begin
            if (last.oor) begin
                n_status = STATUS_RANGE;
            end else begin
                n_coord = last.coord;
            end
        end else if (last.acc > {1'b0, INDEX_MASK}) begin
            n_status = STATUS_RANGE;
            n_index  = INDEX_MASK;
        end else begin
            n_index = last.acc[INDEX_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= s_valid[NDIV];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_coord  <= n_coord;
            r_index  <= n_index;
            r_status <= n_status;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_coord_out_0 = r_coord[0];
    assign o_coord_out_1 = r_coord[1];
    assign o_coord_out_2 = r_coord[2];
    assign o_coord_out_3 = r_coord[3];
    assign o_index_out   = r_index;
    assign o_status      = r_status;

    `GIC_ASSERT_IMP(a_no_dims_zero, i_clk, i_rst_n,
        o_out_valid && (o_status == STATUS_NO_DIMS),
        (o_index_out == '0) && (r_coord == '0), "no-dims result carries data")
    `GIC_ASSERT_IMP(a_split_compose_excl, i_clk, i_rst_n,
        o_out_valid && (o_index_out != '0), r_coord == '0, "index and coordinates both set")
    `GIC_ASSERT_IMP(a_range_no_coords, i_clk, i_rst_n,
        o_out_valid && (o_status == STATUS_RANGE), r_coord == '0, "range error with coordinates")

endmodule

/* dv/grid_index_convert_test.sv */
// ----------------------------------------------------------------------------
// grid_index_convert_test
// Self-checking bench for the grid index converter. Directed and random
// split and compose items run through several grid shapes, sender idling
// and output stall phases, each result checked against a predicted queue.
// ----------------------------------------------------------------------------
module grid_index_convert_test;
    import gic_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY = 70;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct {
        logic               op;
        logic [INDEX_W-1:0] index_in;
        logic [SIZE_W-1:0]  coord [FIELD_DIMS];
    } t_req;

    typedef struct {
        logic [SIZE_W-1:0]  coord [FIELD_DIMS];
        logic [INDEX_W-1:0] index_out;
        logic [1:0]         status;
    } t_conv;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    logic i_op = 1'b0;
    logic [INDEX_W-1:0] i_index_in = '0;
    logic [SIZE_W-1:0] i_coord_in_0 = '0, i_coord_in_1 = '0, i_coord_in_2 = '0, i_coord_in_3 = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    logic [SIZE_W-1:0] o_coord_out_0, o_coord_out_1, o_coord_out_2, o_coord_out_3;
    logic [INDEX_W-1:0] o_index_out;
    logic [1:0] o_status;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [SIZE_W-1:0] i_cfg_data = '0;

    grid_index_convert dut (.*);

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Shadow copy of the configuration.
    logic [2:0]        grid_dims = 3'd1;
    logic [SIZE_W-1:0] grid_size [FIELD_DIMS] = '{1, 1, 1, 1};

    t_req  pending_items [$];
    t_conv expected_conv [$];
    int    mismatches = 0;
    int    send_idle_pct = 0;
    int    recv_stall_pct = 0;
    bit    hold_recv = 1'b0;
    int    idle_cycles = 0;

    function automatic t_conv convert(t_req r);
        t_conv c;
        int unsigned n;
        longint unsigned total, idx, stride, acc;
        n = (grid_dims > 4) ? 4 : grid_dims;
        for (int d = 0; d < FIELD_DIMS; d++) c.coord[d] = '0;
        c.index_out = '0;
        c.status = STATUS_OK;
        if (n == 0) begin
            c.status = STATUS_NO_DIMS;
        end else if (r.op == OP_SPLIT) begin
            idx = r.index_in;
            total = 1;
            for (int d = 0; d < n; d++) begin
                total = total * grid_size[d];
                if (total > 64'h8000_0000) total = 64'h8000_0000;
            end
            if (idx >= total) begin
                c.status = STATUS_RANGE;
            end else begin
                for (int d = 0; d < n; d++) begin
                    stride = 1;
                    for (int e = d + 1; e < n; e++) stride = stride * grid_size[e];
                    c.coord[d] = SIZE_W'(idx / stride);
                    idx = idx - (idx / stride) * stride;
                end
            end
        end else begin
            acc = r.coord[0];
            for (int d = 1; d < n; d++) begin
                acc = grid_size[d] * acc + r.coord[d];
                if (acc > 64'h8000_0000) acc = 64'h8000_0000;
            end
            if (acc > 64'h7FFF_FFFF) begin
                c.status = STATUS_RANGE;
                acc = 64'h7FFF_FFFF;
            end
            c.index_out = INDEX_W'(acc);
        end
        return c;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        mismatches++;
    endtask

    // Driver: offers the head of the pending queue.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                expected_conv.push_back(convert(pending_items.pop_front()));
            end
            if (!(i_in_valid && o_in_stall)) begin
                if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    i_in_valid   <= 1'b1;
                    i_op         <= pending_items[0].op;
                    i_index_in   <= pending_items[0].index_in;
                    i_coord_in_0 <= pending_items[0].coord[0];
                    i_coord_in_1 <= pending_items[0].coord[1];
                    i_coord_in_2 <= pending_items[0].coord[2];
                    i_coord_in_3 <= pending_items[0].coord[3];
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each accepted result and drives the output stall.
    always @(posedge i_clk) begin
        t_conv want;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_conv.size() == 0) begin
                    report_mismatch("unexpected item", 1, 0);
                end else begin
                    want = expected_conv.pop_front();
                    if (o_coord_out_0 !== want.coord[0])
                        report_mismatch("coord_out_0", o_coord_out_0, want.coord[0]);
                    if (o_coord_out_1 !== want.coord[1])
                        report_mismatch("coord_out_1", o_coord_out_1, want.coord[1]);
                    if (o_coord_out_2 !== want.coord[2])
                        report_mismatch("coord_out_2", o_coord_out_2, want.coord[2]);
                    if (o_coord_out_3 !== want.coord[3])
                        report_mismatch("coord_out_3", o_coord_out_3, want.coord[3]);
                    if (o_index_out !== want.index_out)
                        report_mismatch("index_out", o_index_out, want.index_out);
                    if (o_status !== want.status)
                        report_mismatch("status", o_status, want.status);
                end
            end
            i_out_stall <= hold_recv || ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Watchdog on cycles without any accepted item.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (i_cfg_valid && o_cfg_ready) || hold_recv || !i_rst_n) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // Leaves the write channel valid; set_grid drops it after the last write.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [SIZE_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == REG_NUM_DIMS) grid_dims = data[2:0];
        else grid_size[idx - 1] = data;
    endtask

    task automatic drain();
        while (pending_items.size() > 0 || i_in_valid || expected_conv.size() > 0)
            @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
    endtask

    task automatic set_grid(int dims, int s0, int s1, int s2, int s3);
        drain();
        write_reg(REG_NUM_DIMS, SIZE_W'(dims));
        write_reg(REG_DIM_SIZE_0, SIZE_W'(s0));
        write_reg(REG_DIM_SIZE_1, SIZE_W'(s1));
        write_reg(REG_DIM_SIZE_2, SIZE_W'(s2));
        write_reg(REG_DIM_SIZE_3, SIZE_W'(s3));
        i_cfg_valid <= 1'b0;
    endtask

    task automatic queue_item(logic op, logic [INDEX_W-1:0] idx,
                              int c0, int c1, int c2, int c3);
        t_req r;
        r.op = op;
        r.index_in = idx;
        r.coord[0] = SIZE_W'(c0);
        r.coord[1] = SIZE_W'(c1);
        r.coord[2] = SIZE_W'(c2);
        r.coord[3] = SIZE_W'(c3);
        pending_items.push_back(r);
    endtask

    // Random items, mostly inside the current grid so splits succeed.
    task automatic queue_random(int count);
        longint unsigned total;
        int unsigned n;
        logic [INDEX_W-1:0] idx;
        int c [FIELD_DIMS];
        n = (grid_dims > 4) ? 4 : grid_dims;
        total = 1;
        for (int d = 0; d < n; d++) total = total * grid_size[d];
        for (int k = 0; k < count; k++) begin
            if (total > 0 && $urandom_range(9) < 7)
                idx = INDEX_W'({$urandom, $urandom} % (total > 64'h7FFF_FFFF ? 64'h8000_0000 : total));
            else
                idx = INDEX_W'($urandom);
            for (int d = 0; d < FIELD_DIMS; d++) begin
                if ($urandom_range(3) == 0 || grid_size[d] == 0) c[d] = $urandom_range(65535);
                else c[d] = $urandom_range(grid_size[d] - 1);
            end
            queue_item($urandom_range(1), idx, c[0], c[1], c[2], c[3]);
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset grid: one dimension of size one.
        queue_item(OP_SPLIT, 0, 0, 0, 0, 0);
        queue_item(OP_SPLIT, 1, 0, 0, 0, 0);
        queue_item(OP_COMPOSE, 0, 65535, 65535, 65535, 65535);

        // Largest sizes: compose overflow and split at the index limit.
        set_grid(4, 65535, 65535, 65535, 65535);
        queue_item(OP_SPLIT, 31'h7FFF_FFFF, 0, 0, 0, 0);
        queue_item(OP_SPLIT, 0, 0, 0, 0, 0);
        queue_item(OP_COMPOSE, 0, 65535, 65535, 65535, 65535);
        queue_item(OP_COMPOSE, 0, 0, 0, 0, 0);
        queue_item(OP_COMPOSE, 0, 0, 0, 1, 2);

        // No dimensions.
        set_grid(0, 3, 4, 5, 6);
        queue_item(OP_SPLIT, 5, 0, 0, 0, 0);
        queue_item(OP_COMPOSE, 0, 1, 2, 3, 4);

        // Too many dimensions saturates to four.
        set_grid(7, 3, 4, 5, 6);
        queue_item(OP_SPLIT, 359, 0, 0, 0, 0);
        queue_item(OP_SPLIT, 360, 0, 0, 0, 0);
        queue_item(OP_COMPOSE, 0, 2, 3, 4, 5);

        // Zero size empties the grid for splits.
        set_grid(3, 10, 0, 7, 9);
        queue_item(OP_SPLIT, 0, 0, 0, 0, 0);
        queue_item(OP_COMPOSE, 0, 9, 5, 6, 8);

        // Two dimensions, index just inside and just outside.
        set_grid(2, 1000, 1000, 1, 1);
        queue_item(OP_SPLIT, 999999, 0, 0, 0, 0);
        queue_item(OP_SPLIT, 1000000, 0, 0, 0, 0);
        queue_item(OP_COMPOSE, 0, 999, 999, 7, 7);
        queue_item(OP_SPLIT, 31'h5555_5555, 0, 0, 0, 0);
        queue_item(OP_SPLIT, 31'h2AAA_AAAA, 0, 0, 0, 0);

        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 69; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 69; end
                default: begin send_idle_pct = 19; recv_stall_pct = 19; end
            endcase
            case (ph)
                0: set_grid(4, 7, 5, 3, 2);
                1: set_grid(1, 65535, 1, 1, 1);
                2: set_grid(3, 256, 256, 256, 1);
                3: set_grid(4, 65535, 65535, 65535, 65535);
                4: set_grid(2, $urandom_range(1, 65535), $urandom_range(1, 65535), 1, 1);
                5: set_grid(4, 1, 1, 1, 1);
                6: set_grid(4, $urandom_range(1, 300), $urandom_range(1, 300),
                            $urandom_range(1, 300), $urandom_range(1, 300));
                default: set_grid($urandom_range(0, 7), $urandom_range(0, 65535),
                                  $urandom_range(0, 65535), $urandom_range(0, 65535),
                                  $urandom_range(0, 65535));
            endcase
            queue_random(250);
            if (ph == 2) begin
                // Long receiver hold-off while the sender keeps offering items.
                hold_recv = 1'b1;
                repeat (400) @(posedge i_clk);
                hold_recv = 1'b0;
            end
        end
        drain();

        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
